/* src/pcmf_pkg.sv */
// Shared types and constants for the PCM to I2S slot formatter.
// Holds the slot descriptor, queue link structs and register indexes.
// Used by every module in src; depends on nothing.
package pcmf_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] SLOT_FILL = 8'hFF;
	localparam logic [7:0] SIGN_FLIP = 8'h80;

	localparam logic REG_SAMPLE_BITS   = 1'b0;
	localparam logic REG_CHANNEL_COUNT = 1'b1;

	localparam logic [5:0] SAMPLE_BITS_RST   = 6'd16;
	localparam logic [1:0] CHANNEL_COUNT_RST = 2'd2;
	localparam logic [1:0] CHANNEL_MONO      = 2'd1;

	typedef enum logic [2:0] {
		FMT_8,
		FMT_16,
		FMT_24,
		FMT_32,
		FMT_NONE
	} fmt_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic            long_slot;
		logic            dup;
	} slot_t;

	typedef struct packed {
		logic  valid;
		slot_t slot;
	} q_push_t;

	typedef struct packed {
		logic  valid;
		slot_t slot;
	} q_head_t;

endpackage

/* src/pcmf_front.sv */
// Front part: configuration registers, sample gathering and slot building.
// Pushes one slot descriptor into the queue for every completed sample.
// Depends on pcmf_pkg.
module pcmf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic                cfg_index,
	input  logic [5:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                q_full,
	output pcmf_pkg::q_push_t   push
);

	logic [5:0]      sample_bits_q;
	logic [1:0]      channel_count_q;
	logic [7:0]      held_q [0:2];
	logic [1:0]      pos_q;
	pcmf_pkg::fmt_t  fmt;
	logic [1:0]      last_pos;
	logic            completes;
	logic            accept;
	logic [3:0][7:0] s;
	pcmf_pkg::slot_t slot;

	always_comb begin
		unique case (sample_bits_q)
			6'd8:    fmt = pcmf_pkg::FMT_8;
			6'd16:   fmt = pcmf_pkg::FMT_16;
			6'd24:   fmt = pcmf_pkg::FMT_24;
			6'd32:   fmt = pcmf_pkg::FMT_32;
			default: fmt = pcmf_pkg::FMT_NONE;
		endcase
	end

	always_comb begin
		unique case (fmt)
			pcmf_pkg::FMT_16: last_pos = 2'd1;
			pcmf_pkg::FMT_24: last_pos = 2'd2;
			pcmf_pkg::FMT_32: last_pos = 2'd3;
			default:          last_pos = 2'd0;
		endcase
	end

	assign completes = (fmt != pcmf_pkg::FMT_NONE) && (pos_q >= last_pos);
	assign in_stall  = q_full && completes;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		s = {8'h00, held_q[2], held_q[1], held_q[0]};
		s[last_pos] = data_byte;
		slot.dup = (channel_count_q == pcmf_pkg::CHANNEL_MONO);
		unique case (fmt)
			pcmf_pkg::FMT_8: begin
				slot.bytes     = {16'h0000, s[0] - pcmf_pkg::SIGN_FLIP, pcmf_pkg::SLOT_FILL};
				slot.long_slot = 1'b0;
			end
			pcmf_pkg::FMT_16: begin
				slot.bytes     = {16'h0000, s[1], s[0]};
				slot.long_slot = 1'b0;
			end
			pcmf_pkg::FMT_24: begin
				slot.bytes     = {s[0], 8'h00, s[2], s[1]};
				slot.long_slot = 1'b1;
			end
			default: begin
				slot.bytes     = {s[1], s[0], s[3], s[2]};
				slot.long_slot = 1'b1;
			end
		endcase
	end

	assign push.valid = accept && completes;
	assign push.slot  = slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bits_q   <= pcmf_pkg::SAMPLE_BITS_RST;
			channel_count_q <= pcmf_pkg::CHANNEL_COUNT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pcmf_pkg::REG_SAMPLE_BITS:   sample_bits_q <= cfg_data;
				pcmf_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 2'd0;
			held_q[0] <= 8'h00;
			held_q[1] <= 8'h00;
			held_q[2] <= 8'h00;
		end else if (accept && (fmt != pcmf_pkg::FMT_NONE)) begin
			if (completes) begin
				pos_q <= 2'd0;
			end else begin
				pos_q <= pos_q + 2'd1;
				for (int i = 0; i < 3; i++) begin
					if (pos_q == 2'(i)) begin
						held_q[i] <= data_byte;
					end
				end
			end
		end
	end

`ifndef SYNTH
	a_push_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |=> pos_q == 2'd0)
		else $error("position not cleared after a completed sample");
	a_stall_only_on_completion: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (completes && q_full))
		else $error("input stalled on a byte that needs no queue space");
`endif

endmodule

/* src/pcmf_queue.sv */
// Short queue of slot descriptors between the front and back parts.
// Depth is set by pcmf_pkg::QDEPTH; depends on pcmf_pkg.
module pcmf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  pcmf_pkg::q_push_t push,
	output logic              full,
	output pcmf_pkg::q_head_t head,
	input  logic              pop
);

	pcmf_pkg::slot_t             mem_q [pcmf_pkg::QDEPTH];
	logic [pcmf_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [pcmf_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [pcmf_pkg::QCNT_W-1:0] cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign full       = (cnt_q == pcmf_pkg::QCNT_W'(pcmf_pkg::QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.slot  = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == pcmf_pkg::QPTR_W'(pcmf_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == pcmf_pkg::QPTR_W'(pcmf_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pcmf_pkg::QCNT_W'(pcmf_pkg::QDEPTH))
		else $error("queue count beyond its depth");
	a_push_never_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("descriptor pushed into a full queue");
`endif

endmodule

/* src/pcmf_back.sv */
// Back part: walks the head slot descriptor and sends its bytes one a cycle
// unless stalled. Mono slots are sent twice; the output register decouples
// the stall. Depends on pcmf_pkg.
module pcmf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pcmf_pkg::q_head_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              run_end
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_end_q;
	logic       advance;
	logic       load;
	logic [2:0] idx_last;
	logic       is_last;
	logic [1:0] sel;

	assign advance  = !out_valid_q || !out_stall;
	assign load     = advance && head.valid;
	assign idx_last = {head.slot.long_slot && head.slot.dup,
		head.slot.long_slot || head.slot.dup, 1'b1};
	assign is_last  = (idx_q == idx_last);
	assign sel      = head.slot.long_slot ? idx_q[1:0] : {1'b0, idx_q[0]};
	assign pop      = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= head.valid;
			end
			if (load) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.slot.bytes[sel];
			run_end_q  <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_end   = run_end_q;

`ifndef SYNTH
	a_mid_run_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd0 |-> head.valid)
		else $error("slot walk in progress with an empty queue");
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 3'd0)
		else $error("byte index not cleared after the last byte of a slot");
`endif

endmodule

/* src/pcm_to_i2s_slot_formatter_core.sv */
// Top level of the PCM to I2S slot formatter: front, descriptor queue, back.
// Depends on pcmf_pkg, pcmf_front, pcmf_queue and pcmf_back.
//
//   channel | signals                                  | direction
//   input   | in_valid, in_stall, data_byte            | byte stream in
//   output  | out_valid, out_stall, out_byte, run_end  | slot bytes out
//   config  | cfg_write, cfg_index, cfg_data           | register writes
//
// A byte that does not complete a sample is never stalled. A completing
// byte queues a descriptor that the back part sends as 2, 4 or 8 bytes, one
// per cycle while out_stall is low, so the output byte rate sets the
// sustained input rate. The two-entry queue lets the front keep taking
// bytes while the back sends. Reset clears the held bytes, the position and
// the queue and restores the registers to 16-bit stereo.
module pcm_to_i2s_slot_formatter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end
);

	pcmf_pkg::q_push_t push;
	pcmf_pkg::q_head_t head;
	logic              q_full;
	logic              pop;

	pcmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (push)
	);

	pcmf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	pcmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_end   (run_end)
	);

endmodule
